@@ hdl/lprd_pkg.sv @@
// Shared types and constants for the length-prefixed response deframer.
`default_nettype none

package lprd_pkg;

   // Decoded length width and its saturation value
   localparam int LEN_W = 17;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // Framing characters
   localparam logic [7:0] CHAR_START = 8'h52;   // 'R'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;   // '9'
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Result kinds carried on tuser
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_EMPTY   = 1'b1;

   // Length field parser state
   typedef struct packed {
      logic [LEN_W-1:0] accum;
      logic             closed;
      logic             started;
   } len_state_type;

endpackage

`default_nettype wire

@@ hdl/length_prefixed_response_deframer.sv @@
// Top level: byte-stream deframer for 'R'-prefixed, length-counted responses.
//
// Usage:
//   req channel carries one received serial byte per request (req_tdata).
//   While idle, bytes are dropped until an 'R' start byte. The header then
//   holds one error-code byte, LENGTH_DIGITS length characters (parsed like
//   strtol: leading blanks skipped, digits up to the first non-digit) and
//   two line-end bytes. Each following payload byte comes out on the rsp
//   channel with rsp_tlast on the final one; a zero length yields one
//   empty-completion result (rsp_tuser high) on the second line-end byte.
//   Output: each result is registered and appears in the cycle after the request that causes it.
//   Throughput: one request per cycle unless the result register stalls; the per-byte state update is a
//   single combinational step between the accepted byte and the result
//   register.
//   Stall: the result register holds while rsp_tready is low, and a new
//   request is taken only when that register is empty or being drained.
//   Reset: synchronous, returns to idle with an empty result register.
`default_nettype none

module length_prefixed_response_deframer #(
   parameter int LENGTH_DIGITS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [7:0] rx_byte
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   // response: [7:0] data_byte, [24:8] frame_length, [32:25] error_digit, zero fill
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,
   output      logic        rsp_tlast,
   // response: [0] kind
   output      logic        rsp_tuser
);

   localparam int IDX_W = $clog2(LENGTH_DIGITS + 3);
   localparam logic [IDX_W-1:0] IDX_LEN_END  = IDX_W'(LENGTH_DIGITS);
   localparam logic [IDX_W-1:0] IDX_HDR_LAST = IDX_W'(LENGTH_DIGITS + 2);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam int LW = lprd_pkg::LEN_W;

   logic [1:0]                phase_ff, phase_in;
   logic [IDX_W-1:0]          index_ff, index_in;
   lprd_pkg::len_state_type   len_ff, len_in, len_next;
   logic [LW-1:0]             count_ff, count_in, count_inc;
   logic [7:0]                err_ff, err_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_kind_ff, out_kind_in;
   logic [7:0]                out_data_ff, out_data_in;
   logic                      out_last_ff, out_last_in;
   logic [LW-1:0]             out_len_ff, out_len_in;
   logic [7:0]                out_err_ff, out_err_in;

   logic                      take;
   logic                      emit;

   // Accept while the result register is empty or draining
   assign req_tready = !out_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   lprd_len_parse u_len_parse (
      .char_byte (req_tdata),
      .cur       (len_ff),
      .nxt       (len_next)
   );

   assign count_inc = count_ff + LW'(1);

   // Advance the framing state for one byte
   always_comb begin
      phase_in    = phase_ff;
      index_in    = index_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      emit        = 1'b0;
      out_kind_in = lprd_pkg::KIND_PAYLOAD;
      out_data_in = 8'd0;
      out_last_in = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            index_in = index_ff + IDX_W'(1);
            if (index_ff == '0) begin
               err_in = req_tdata - lprd_pkg::CHAR_ZERO;
            end else if (index_ff <= IDX_LEN_END) begin
               len_in = len_next;
            end else if (index_ff >= IDX_HDR_LAST) begin
               index_in = '0;
               if (len_ff.accum != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in    = PH_IDLE;
                  emit        = 1'b1;
                  out_kind_in = lprd_pkg::KIND_EMPTY;
                  out_last_in = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            count_in    = count_inc;
            emit        = 1'b1;
            out_data_in = req_tdata;
            out_last_in = (count_inc == len_ff.accum);
            if (out_last_in) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_tdata == lprd_pkg::CHAR_START) begin
               phase_in = PH_HEADER;
               index_in = '0;
               len_in   = '0;
               count_in = '0;
            end
         end
      endcase
      out_len_in = len_ff.accum;
      out_err_in = err_ff;
   end

   // Hold a result until taken, load a new one on emit
   assign out_valid_in = (take && emit) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         index_ff     <= '0;
         len_ff       <= '0;
         count_ff     <= '0;
         err_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            index_ff <= index_in;
            len_ff   <= len_in;
            count_ff <= count_in;
            err_ff   <= err_in;
         end
      end
   end

   // Result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
         out_len_ff  <= out_len_in;
         out_err_ff  <= out_err_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_err_ff, out_len_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule

`default_nettype wire

@@ hdl/lprd_len_parse.sv @@
// Next-state logic for one character of the decimal length field.
`default_nettype none

module lprd_len_parse (
   input  wire logic                  [7:0] char_byte,
   input  wire lprd_pkg::len_state_type     cur,
   output      lprd_pkg::len_state_type     nxt
);

   logic                       is_digit;
   logic                       is_blank;
   logic [3:0]                 digit;
   logic [lprd_pkg::LEN_W+3:0] times_ten;

   // Classify the character
   always_comb begin
      is_digit = (char_byte >= lprd_pkg::CHAR_ZERO) && (char_byte <= lprd_pkg::CHAR_NINE);
      is_blank = (char_byte == lprd_pkg::CHAR_SPACE) ||
                 (char_byte inside {[lprd_pkg::CHAR_TAB:lprd_pkg::CHAR_CR]});
      digit    = 4'(char_byte - lprd_pkg::CHAR_ZERO);
   end

   // Multiply by ten as shift-add and add the new digit
   assign times_ten = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0}
                    + {{(lprd_pkg::LEN_W){1'b0}}, digit};

   // Accumulate with saturation, skip leading blanks, close on anything else
   always_comb begin
      nxt = cur;
      if (!cur.closed) begin
         if (is_digit) begin
            nxt.started = 1'b1;
            if (times_ten[lprd_pkg::LEN_W+3:lprd_pkg::LEN_W] != 4'd0) begin
               nxt.accum = lprd_pkg::LEN_MAX;
            end else begin
               nxt.accum = times_ten[lprd_pkg::LEN_W-1:0];
            end
         end else if (!(is_blank && !cur.started)) begin
            nxt.closed = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire
